// ===== sv/ppp_pkg.sv =====
package ppp_pkg;

    // Widths of the datapath.
    localparam int CoordW = 35;   // camera coordinate, signed
    localparam int MagW   = 34;   // magnitude of a camera coordinate
    localparam int HalfW  = 17;   // half of a magnitude for the split multiply
    localparam int PartW  = 33;   // 16 x 17 partial product
    localparam int RemW   = 62;   // divider remainder and shifted divisor
    localparam int QuoW   = 25;   // quotient bits kept; larger saturates anyway
    localparam int SumW   = 27;   // pixel value before saturation

    localparam logic signed [23:0] PixMax = 24'sh7FFFFF;
    localparam logic signed [23:0] PixMin = -24'sh800000;

    // Status codes.
    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_BEHIND  = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_POSE0  = 3'd0;
    localparam logic [2:0] REG_POSE1  = 3'd1;
    localparam logic [2:0] REG_POSE2  = 3'd2;
    localparam logic [2:0] REG_FOCAL  = 3'd3;
    localparam logic [2:0] REG_CENTER = 3'd4;
    localparam logic [2:0] REG_SIZE   = 3'd5;
    localparam logic [2:0] REG_MARGIN = 3'd6;

    // Item as it moves through the divider stages.
    typedef struct packed {
        logic            behind;
        logic            neg_u;
        logic            neg_v;
        logic            ovf_u;
        logic            ovf_v;
        logic [RemW-1:0] den;
        logic [RemW-1:0] rem_u;
        logic [RemW-1:0] rem_v;
        logic [QuoW-1:0] quo_u;
        logic [QuoW-1:0] quo_v;
    } div_t;

endpackage

// ===== sv/ppp_transform.sv =====
module ppp_transform
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [15:0]                  px,
    input  logic signed [15:0]                  py,
    input  logic signed [15:0]                  pz,
    input  logic [63:0]                         pose0,
    input  logic [63:0]                         pose1,
    input  logic [63:0]                         pose2,
    output logic                                out_valid,
    output logic signed [ppp_pkg::CoordW-1:0]   xc,
    output logic signed [ppp_pkg::CoordW-1:0]   yc,
    output logic signed [ppp_pkg::CoordW-1:0]   zc
);

    logic [63:0]        rows [3];
    logic signed [31:0] prod_reg [3][3];
    logic signed [27:0] trans_reg [3];
    logic               v1_reg;
    logic               v2_reg;
    logic signed [ppp_pkg::CoordW-1:0] cam_reg [3];

    assign rows[0] = pose0;
    assign rows[1] = pose1;
    assign rows[2] = pose2;

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // First stage: the nine rotation products and the scaled translation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= $signed(rows[r][63:48]) * px;
                prod_reg[r][1] <= $signed(rows[r][47:32]) * py;
                prod_reg[r][2] <= $signed(rows[r][31:16]) * pz;
                trans_reg[r]   <= $signed({rows[r][15:0], 12'b0});
            end
        end
    end

    // Second stage: sum into camera coordinates.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                cam_reg[r] <= ppp_pkg::CoordW'(prod_reg[r][0])
                            + ppp_pkg::CoordW'(prod_reg[r][1])
                            + ppp_pkg::CoordW'(prod_reg[r][2])
                            + ppp_pkg::CoordW'(trans_reg[r]);
            end
        end
    end

    assign out_valid = v2_reg;
    assign xc = cam_reg[0];
    assign yc = cam_reg[1];
    assign zc = cam_reg[2];

endmodule

// ===== sv/ppp_scale.sv =====
module ppp_scale
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [ppp_pkg::CoordW-1:0]  xc,
    input  logic signed [ppp_pkg::CoordW-1:0]  yc,
    input  logic signed [ppp_pkg::CoordW-1:0]  zc,
    input  logic [15:0]                        fu,
    input  logic [15:0]                        fv,
    output logic                               out_valid,
    output ppp_pkg::div_t                      out_item
);

    localparam int RW = ppp_pkg::RemW;
    localparam int HW = ppp_pkg::HalfW;

    logic [ppp_pkg::MagW-1:0] mag_u;
    logic [ppp_pkg::MagW-1:0] mag_v;
    logic                     v3_reg;
    logic                     v4_reg;
    logic                     v5_reg;

    // Stage three registers.
    logic [ppp_pkg::PartW-1:0] pu_lo_reg, pu_hi_reg, pv_lo_reg, pv_hi_reg;
    logic [RW-1:0]             den3_reg;
    logic                      neg_u3_reg, neg_v3_reg, behind3_reg;

    // Stage four registers.
    logic [RW-1:0] nu4_reg, nv4_reg, den4_reg;
    logic          neg_u4_reg, neg_v4_reg, behind4_reg;

    // Stage five register.
    ppp_pkg::div_t item5_reg;
    logic [RW-1:0] num_u, num_v, dd;

    assign mag_u = xc[ppp_pkg::CoordW-1] ? ppp_pkg::MagW'(-xc) : ppp_pkg::MagW'(xc);
    assign mag_v = yc[ppp_pkg::CoordW-1] ? ppp_pkg::MagW'(-yc) : ppp_pkg::MagW'(yc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage three: focal length times magnitude, split in two halves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_lo_reg   <= fu * mag_u[HW-1:0];
            pu_hi_reg   <= fu * mag_u[2*HW-1:HW];
            pv_lo_reg   <= fv * mag_v[HW-1:0];
            pv_hi_reg   <= fv * mag_v[2*HW-1:HW];
            den3_reg    <= RW'(zc[ppp_pkg::MagW-1:0]);
            neg_u3_reg  <= xc[ppp_pkg::CoordW-1];
            neg_v3_reg  <= yc[ppp_pkg::CoordW-1];
            behind3_reg <= (zc <= 0);
        end
    end

    // Stage four: join the halves and scale by sixteen.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nu4_reg     <= ((RW'(pu_hi_reg) << HW) + RW'(pu_lo_reg)) << 4;
            nv4_reg     <= ((RW'(pv_hi_reg) << HW) + RW'(pv_lo_reg)) << 4;
            den4_reg    <= den3_reg;
            neg_u4_reg  <= neg_u3_reg;
            neg_v4_reg  <= neg_v3_reg;
            behind4_reg <= behind3_reg;
        end
    end

    // Stage five: rounding numerator, doubled divisor and range check.
    assign num_u = (nu4_reg << 1) + den4_reg;
    assign num_v = (nv4_reg << 1) + den4_reg;
    assign dd    = den4_reg << 1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item5_reg.behind <= behind4_reg;
            item5_reg.neg_u  <= neg_u4_reg;
            item5_reg.neg_v  <= neg_v4_reg;
            item5_reg.ovf_u  <= num_u >= (dd << ppp_pkg::QuoW);
            item5_reg.ovf_v  <= num_v >= (dd << ppp_pkg::QuoW);
            item5_reg.den    <= dd;
            item5_reg.rem_u  <= num_u;
            item5_reg.rem_v  <= num_v;
            item5_reg.quo_u  <= '0;
            item5_reg.quo_v  <= '0;
        end
    end

    assign out_valid = v5_reg;
    assign out_item  = item5_reg;

endmodule

// ===== sv/ppp_div.sv =====
module ppp_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  ppp_pkg::div_t in_item,
    output logic          out_valid,
    output ppp_pkg::div_t out_item
);

    localparam int QW = ppp_pkg::QuoW;

    logic          v_reg [QW];
    ppp_pkg::div_t item_reg [QW];

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        localparam int Bit = QW - 1 - s;
        ppp_pkg::div_t src;
        ppp_pkg::div_t nxt;
        logic          src_v;
        logic [ppp_pkg::RemW-1:0] dsh;

        if (s == 0)
        begin : g_first
            assign src   = in_item;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = item_reg[s-1];
            assign src_v = v_reg[s-1];
        end

        assign dsh = src.den << Bit;

        always_comb
        begin
            nxt = src;
            if (src.rem_u >= dsh)
            begin
                nxt.rem_u      = src.rem_u - dsh;
                nxt.quo_u[Bit] = 1'b1;
            end
            if (src.rem_v >= dsh)
            begin
                nxt.rem_v      = src.rem_v - dsh;
                nxt.quo_v[Bit] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[s] <= nxt;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_item  = item_reg[QW-1];

endmodule

// ===== sv/ppp_finish.sv =====
module ppp_finish
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  ppp_pkg::div_t      in_item,
    input  logic [15:0]        cu,
    input  logic [15:0]        cv,
    input  logic [15:0]        width,
    input  logic [15:0]        height,
    input  logic [15:0]        margin,
    output logic               out_valid,
    output logic signed [23:0] pixel_u,
    output logic signed [23:0] pixel_v,
    output logic [1:0]         status
);

    localparam int SW = ppp_pkg::SumW;

    logic signed [SW-1:0] qu, qv, su, sv, lo_lim, hi_u, hi_v;
    logic signed [23:0]   sat_u, sat_v;
    logic                 in_u, in_v;
    logic                 v_reg;
    logic signed [23:0]   pu_reg, pv_reg;
    logic [1:0]           st_reg;

    // Signed offsets from the principal point.
    assign qu = in_item.neg_u ? -SW'(in_item.quo_u) : SW'(in_item.quo_u);
    assign qv = in_item.neg_v ? -SW'(in_item.quo_v) : SW'(in_item.quo_v);
    assign su = $signed(SW'({cu, 4'b0})) + qu;
    assign sv = $signed(SW'({cv, 4'b0})) + qv;

    // Bordered image limits in 1/16 pixel.
    assign lo_lim = $signed(SW'({margin, 4'b0}));
    assign hi_u   = $signed(SW'({width, 4'b0})) - lo_lim;
    assign hi_v   = $signed(SW'({height, 4'b0})) - lo_lim;

    assign in_u = !in_item.ovf_u && (lo_lim < su) && (su < hi_u);
    assign in_v = !in_item.ovf_v && (lo_lim < sv) && (sv < hi_v);

    // Saturation; an overflowed quotient always lands on a rail.
    always_comb
    begin
        if (in_item.ovf_u)
            sat_u = in_item.neg_u ? ppp_pkg::PixMin : ppp_pkg::PixMax;
        else if (su > SW'(ppp_pkg::PixMax))
            sat_u = ppp_pkg::PixMax;
        else if (su < SW'(ppp_pkg::PixMin))
            sat_u = ppp_pkg::PixMin;
        else
            sat_u = su[23:0];

        if (in_item.ovf_v)
            sat_v = in_item.neg_v ? ppp_pkg::PixMin : ppp_pkg::PixMax;
        else if (sv > SW'(ppp_pkg::PixMax))
            sat_v = ppp_pkg::PixMax;
        else if (sv < SW'(ppp_pkg::PixMin))
            sat_v = ppp_pkg::PixMin;
        else
            sat_v = sv[23:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_item.behind)
            begin
                pu_reg <= '0;
                pv_reg <= '0;
                st_reg <= ppp_pkg::ST_BEHIND;
            end
            else
            begin
                pu_reg <= sat_u;
                pv_reg <= sat_v;
                st_reg <= (in_u && in_v) ? ppp_pkg::ST_INSIDE : ppp_pkg::ST_OUTSIDE;
            end
        end
    end

    assign out_valid = v_reg;
    assign pixel_u   = pu_reg;
    assign pixel_v   = pv_reg;
    assign status    = st_reg;

endmodule

// ===== sv/ppp_cfg.sv =====
module ppp_cfg
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output logic [63:0] pose0,
    output logic [63:0] pose1,
    output logic [63:0] pose2,
    output logic [31:0] focal,
    output logic [31:0] center,
    output logic [31:0] size,
    output logic [15:0] margin
);

    logic [63:0] pose0_reg, pose1_reg, pose2_reg;
    logic [31:0] focal_reg, center_reg, size_reg;
    logic [15:0] margin_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    // Register writes; an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose0_reg  <= 64'd1152921504606846976;
            pose1_reg  <= 64'd17592186044416;
            pose2_reg  <= 64'd268435456;
            focal_reg  <= 32'd131074000;
            center_reg <= 32'd104858500;
            size_reg   <= 32'd209717000;
            margin_reg <= 16'd40;
        end
        else if (wr)
        begin
            unique case (idx)
                ppp_pkg::REG_POSE0:  pose0_reg  <= pwdata;
                ppp_pkg::REG_POSE1:  pose1_reg  <= pwdata;
                ppp_pkg::REG_POSE2:  pose2_reg  <= pwdata;
                ppp_pkg::REG_FOCAL:  focal_reg  <= pwdata[31:0];
                ppp_pkg::REG_CENTER: center_reg <= pwdata[31:0];
                ppp_pkg::REG_SIZE:   size_reg   <= pwdata[31:0];
                ppp_pkg::REG_MARGIN: margin_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (idx)
            ppp_pkg::REG_POSE0:  prdata = pose0_reg;
            ppp_pkg::REG_POSE1:  prdata = pose1_reg;
            ppp_pkg::REG_POSE2:  prdata = pose2_reg;
            ppp_pkg::REG_FOCAL:  prdata = {32'b0, focal_reg};
            ppp_pkg::REG_CENTER: prdata = {32'b0, center_reg};
            ppp_pkg::REG_SIZE:   prdata = {32'b0, size_reg};
            ppp_pkg::REG_MARGIN: prdata = {48'b0, margin_reg};
            default:             prdata = '0;
        endcase
    end

    assign pose0  = pose0_reg;
    assign pose1  = pose1_reg;
    assign pose2  = pose2_reg;
    assign focal  = focal_reg;
    assign center = center_reg;
    assign size   = size_reg;
    assign margin = margin_reg;

endmodule

// ===== sv/pinhole_point_projection_top.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata: point_x, point_y, point_z
// m_axis    out        tdata: pixel_u, pixel_v; tuser: status
// apb       in/out     seven registers at byte address 8*i
//
// One point enters per cycle while the pipeline advances; each result passes
// the transform, scaling, the 25 stages of the restoring divider and finish.
// The whole pipeline advances together and halts while a result waits untaken.
// rst_n clears the valid bits and loads the registers' reset values.
module pinhole_point_projection_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // point_x, point_y, point_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pixel_u, pixel_v
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic        en;
    logic [63:0] pose0, pose1, pose2;
    logic [31:0] focal, center, size;
    logic [15:0] margin;
    logic        t_valid, s_valid, d_valid;
    logic signed [ppp_pkg::CoordW-1:0] xc, yc, zc;
    ppp_pkg::div_t s_item, d_item;
    logic signed [23:0] pu, pv;

    // Global advance: move when the output slot is free or being taken.
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    ppp_cfg u_cfg
    (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .pose0, .pose1, .pose2, .focal, .center, .size, .margin
    );

    ppp_transform u_transform
    (
        .clk, .rst_n, .en,
        .in_valid  (s_axis_tvalid),
        .px        ($signed(s_axis_tdata[15:0])),
        .py        ($signed(s_axis_tdata[31:16])),
        .pz        ($signed(s_axis_tdata[47:32])),
        .pose0, .pose1, .pose2,
        .out_valid (t_valid),
        .xc, .yc, .zc
    );

    ppp_scale u_scale
    (
        .clk, .rst_n, .en,
        .in_valid  (t_valid),
        .xc, .yc, .zc,
        .fu        (focal[31:16]),
        .fv        (focal[15:0]),
        .out_valid (s_valid),
        .out_item  (s_item)
    );

    ppp_div u_div
    (
        .clk, .rst_n, .en,
        .in_valid  (s_valid),
        .in_item   (s_item),
        .out_valid (d_valid),
        .out_item  (d_item)
    );

    ppp_finish u_finish
    (
        .clk, .rst_n, .en,
        .in_valid  (d_valid),
        .in_item   (d_item),
        .cu        (center[31:16]),
        .cv        (center[15:0]),
        .width     (size[31:16]),
        .height    (size[15:0]),
        .margin,
        .out_valid (m_axis_tvalid),
        .pixel_u   (pu),
        .pixel_v   (pv),
        .status    (m_axis_tuser)
    );

    assign m_axis_tdata = {pv, pu};

`ifndef SYNTH
    // A point behind the camera leaves zero pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ppp_pkg::ST_BEHIND) |-> m_axis_tdata == '0)
        else $error("behind-camera result with nonzero pixels");

    // Only the three defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ppp_pkg::ST_INSIDE ||
                           m_axis_tuser == ppp_pkg::ST_BEHIND ||
                           m_axis_tuser == ppp_pkg::ST_OUTSIDE))
        else $error("undefined status code");

    // A waiting result halts the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while the pipeline is halted");

    // An inside result lies within the 24-bit rails and is not on the upper one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ppp_pkg::ST_INSIDE) |->
            (pu != ppp_pkg::PixMax && pv != ppp_pkg::PixMax))
        else $error("inside result on the saturation rail");
`endif

endmodule
